### src/assert_macros.svh
// Assertion macros for the expiry-ranked address table.
// The macros sample on clk and are disabled while rst is high; they expect both names in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/ert_pkg.sv
// Shared types and constants for the expiry-ranked address table.
// Used by the register block, controller, datapath and top level; depends on nothing.
package ert_pkg;

  // Default sizes of the table and its stored fields.
  localparam int DEF_CAPACITY     = 10;
  localparam int DEF_ADDR_WIDTH   = 32;
  localparam int DEF_EXPIRE_WIDTH = 32;

  // Fixed widths of the port fields.
  localparam int FIELD_WIDTH = 32;
  localparam int COUNT_WIDTH = 4;
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_ACCEPTED_TAG = 1'b0;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a report and evaluate it against the table
    logic apply;  // update the table and load the result register
  } ert_cmd_t;

endpackage

### src/ert_regs.sv
// Configuration register block: APB-style write and read of accepted_tag.
// Depends on ert_pkg for the address and data widths and the register index.
module ert_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ert_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [ert_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [ert_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                           pready,
  output logic [ert_pkg::FIELD_WIDTH-1:0] accepted_tag
);
  import ert_pkg::*;

  logic wr_en;
  logic reg_sel;

  // Register index sits above the byte offset.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_ACCEPTED_TAG);

  // The tag register resets to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_tag <= '0;
    end else if (wr_en) begin
      accepted_tag <= pwdata;
    end
  end

  // Read back; addresses beyond the register list read as zero.
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_ACCEPTED_TAG) begin
      prdata = accepted_tag;
    end
  end

endmodule

### src/ert_ctrl.sv
// Controller for the expiry-ranked address table: sequences load and apply and owns
// the result-valid flag. Depends on ert_pkg for the command struct.
module ert_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output ert_pkg::ert_cmd_t cmd
);
  import ert_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  // A report is taken only in idle; the update waits for a free result register.
  assign in_stall  = (state == ST_BUSY);
  assign cmd.load  = in_valid && !in_stall;
  assign cmd.apply = (state == ST_BUSY) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (cmd.apply) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until the receiver takes it.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.apply) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### src/ert_dpath.sv
// Datapath for the expiry-ranked address table: sorted slot registers, parallel
// match and order compares, shift-insert update and result register. Depends on ert_pkg.
module ert_dpath #(
  parameter int CAPACITY     = ert_pkg::DEF_CAPACITY,
  parameter int ADDR_WIDTH   = ert_pkg::DEF_ADDR_WIDTH,
  parameter int EXPIRE_WIDTH = ert_pkg::DEF_EXPIRE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ert_pkg::ert_cmd_t               cmd,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] accepted_tag,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] report_tag,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] entry_addr,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] entry_expire,
  output logic                            status,
  output logic [ert_pkg::COUNT_WIDTH-1:0] entry_count,
  output logic                            front_valid,
  output logic [ert_pkg::FIELD_WIDTH-1:0] front_addr,
  output logic [ert_pkg::FIELD_WIDTH-1:0] front_expire
);
  import ert_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AK = (ADDR_WIDTH < FIELD_WIDTH) ? ADDR_WIDTH : FIELD_WIDTH;
  localparam int EK = (EXPIRE_WIDTH < FIELD_WIDTH) ? EXPIRE_WIDTH : FIELD_WIDTH;

  // Sorted entries, latest expiry in slot 0, and the fill count.
  logic [ADDR_WIDTH-1:0]   slot_addr   [CAPACITY];
  logic [EXPIRE_WIDTH-1:0] slot_expire [CAPACITY];
  logic [CW-1:0]           count;

  // Report captured at load, with the compare vectors against the table.
  logic                    tag_ok;
  logic [ADDR_WIDTH-1:0]   key_addr;
  logic [EXPIRE_WIDTH-1:0] key_expire;
  logic [CAPACITY-1:0]     hit_vec;
  logic [CAPACITY-1:0]     keep_vec;
  logic [CAPACITY-1:0]     raise_vec;

  logic [ADDR_WIDTH-1:0]   in_addr;
  logic [EXPIRE_WIDTH-1:0] in_expire;
  logic [CAPACITY-1:0]     hit_now;
  logic [CAPACITY-1:0]     keep_now;
  logic [CAPACITY-1:0]     raise_now;

  logic [CAPACITY-1:0]     after_hit;
  logic                    do_write;
  logic [ADDR_WIDTH-1:0]   addr_next   [CAPACITY];
  logic [EXPIRE_WIDTH-1:0] expire_next [CAPACITY];
  logic [CW-1:0]           count_next;

  // Keep only the stored width of each key field.
  assign in_addr   = ADDR_WIDTH'(entry_addr[AK-1:0]);
  assign in_expire = EXPIRE_WIDTH'(entry_expire[EK-1:0]);

  // Per-slot compares: address match, and whether the slot stays ahead of the report.
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      hit_now[j]   = (CW'(j) < count) && (slot_addr[j] == in_addr);
      keep_now[j]  = (CW'(j) < count) && !(slot_expire[j] < in_expire);
      raise_now[j] = hit_now[j] && (slot_expire[j] < in_expire);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_ok     <= (report_tag == accepted_tag);
      key_addr   <= in_addr;
      key_expire <= in_expire;
      hit_vec    <= hit_now;
      keep_vec   <= keep_now;
      raise_vec  <= raise_now;
    end
  end

  // A slot past the matched entry is untouched by a raise.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      after_hit[k] = |(hit_vec & ({CAPACITY{1'b1}} >> (CAPACITY - k)));
    end
  end

  // Insert a new entry, or move a raised one up; equal expiries stay ahead.
  assign do_write = tag_ok && (!(|hit_vec) || (|raise_vec));

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      addr_next[k]   = slot_addr[k];
      expire_next[k] = slot_expire[k];
      if (do_write && !keep_vec[k] && !after_hit[k]) begin
        if (k == 0) begin
          addr_next[k]   = key_addr;
          expire_next[k] = key_expire;
        end else if (keep_vec[k-1]) begin
          addr_next[k]   = key_addr;
          expire_next[k] = key_expire;
        end else begin
          addr_next[k]   = slot_addr[k-1];
          expire_next[k] = slot_expire[k-1];
        end
      end
    end
  end

  // Only a new address grows the table, up to its capacity.
  always_comb begin
    count_next = count;
    if (tag_ok && !(|hit_vec) && (count != CW'(CAPACITY))) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int k = 0; k < CAPACITY; k++) begin
        slot_addr[k]   <= addr_next[k];
        slot_expire[k] <= expire_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  // Result register, loaded from the updated table.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status       <= tag_ok ? STATUS_OK : STATUS_REJECT;
      entry_count  <= COUNT_WIDTH'(count_next);
      front_valid  <= (count_next != '0);
      front_addr   <= (count_next != '0) ? FIELD_WIDTH'(addr_next[0][AK-1:0]) : '0;
      front_expire <= (count_next != '0) ? FIELD_WIDTH'(expire_next[0][EK-1:0]) : '0;
    end
  end

endmodule

### src/expiry_ranked_address_table_core.sv
// Top level of the expiry-ranked address table: register block, controller and datapath.
// Depends on ert_pkg, ert_regs, ert_ctrl, ert_dpath and assert_macros.svh.
//
//   chan    dir  handshake                  payload
//   in      in   in_valid/in_stall          report_tag, entry_addr, entry_expire
//   out     out  out_valid/out_stall        status, entry_count, front_valid, front_addr, front_expire
//   config  in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each report is first captured and compared against every slot in parallel, then shift-inserted
// into the sorted slot registers while the result is loaded.
// The next report is taken while the previous result still waits; the update then holds
// until the result register is free. Reset (synchronous, active high) empties the table,
// clears accepted_tag and drops any pending result.
`include "assert_macros.svh"
module expiry_ranked_address_table_core #(
  parameter int CAPACITY     = ert_pkg::DEF_CAPACITY,
  parameter int ADDR_WIDTH   = ert_pkg::DEF_ADDR_WIDTH,
  parameter int EXPIRE_WIDTH = ert_pkg::DEF_EXPIRE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ert_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [ert_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [ert_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] report_tag,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] entry_addr,
  input  logic [ert_pkg::FIELD_WIDTH-1:0] entry_expire,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            status,
  output logic [ert_pkg::COUNT_WIDTH-1:0] entry_count,
  output logic                            front_valid,
  output logic [ert_pkg::FIELD_WIDTH-1:0] front_addr,
  output logic [ert_pkg::FIELD_WIDTH-1:0] front_expire
);
  import ert_pkg::*;

  logic [FIELD_WIDTH-1:0] accepted_tag;
  ert_cmd_t               cmd;

  // Configuration registers.
  ert_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .accepted_tag (accepted_tag)
  );

  // Sequencing of capture and update.
  ert_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Sorted table and result register.
  ert_dpath #(
    .CAPACITY     (CAPACITY),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .EXPIRE_WIDTH (EXPIRE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .accepted_tag (accepted_tag),
    .report_tag   (report_tag),
    .entry_addr   (entry_addr),
    .entry_expire (entry_expire),
    .status       (status),
    .entry_count  (entry_count),
    .front_valid  (front_valid),
    .front_addr   (front_addr),
    .front_expire (front_expire)
  );

  // A captured report blocks the input until its update is done.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // The reported count never exceeds the table capacity.
  `ASSERT_IMPLY(a_count_in_range, out_valid, entry_count <= CAPACITY)
  // An empty front is reported only with a zero count.
  `ASSERT_IMPLY(a_front_matches_count, out_valid && !front_valid, entry_count == '0)
  // An empty front carries zero payload.
  `ASSERT_IMPLY(a_empty_front_zero, out_valid && !front_valid,
                front_addr == '0 && front_expire == '0)

endmodule
